// ----- sv/tsr_pkg.sv -----
// tsr_pkg: shared constants for the triangle span rasterizer.
// No dependencies; imported by the rasterizer top level.
package tsr_pkg;

	localparam int CLIP_W  = 11;
	localparam int COLOR_W = 16;
	localparam int EDGE_W  = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_NEXT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

	localparam logic [CLIP_W-1:0] CLIP_LEFT_RST   = 11'd0;
	localparam logic [CLIP_W-1:0] CLIP_RIGHT_RST  = 11'd639;
	localparam logic [CLIP_W-1:0] CLIP_TOP_RST    = 11'd0;
	localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RST = 11'd479;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MORE,
		PH_FINAL
	} phase_t;

endpackage

// ----- sv/tsr_div.sv -----
// tsr_div: iterative signed divider, one quotient bit per cycle, truncating.
// Used by the rasterizer top level; no package dependencies.
module tsr_div #(
	parameter int MAG_W = 28,
	parameter int DEN_W = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [MAG_W:0] num,
	input  logic [DEN_W-1:0]   den,
	output logic               done,
	output logic signed [MAG_W:0] quo
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MAG_W-1:0]   dvd_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W:0]     shifted;
	logic               fits;
	logic signed [MAG_W:0] num_abs;

	assign num_abs = num[MAG_W] ? -num : num;
	assign shifted = {rem_q, dvd_q[MAG_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= num[MAG_W];
				dvd_q  <= num_abs[MAG_W-1:0];
				rem_q  <= '0;
				den_q  <= den;
				cnt_q  <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
				dvd_q <= {dvd_q[MAG_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule

// ----- sv/triangle_span_rasterizer.sv -----
// triangle_span_rasterizer: flat-shaded triangle to horizontal span converter.
// Depends on tsr_pkg and tsr_div (shared iterative divider).
//
// A load word (cmd = 0) takes three vertices and a colour and answers with one
// word that only carries the rejected flag. A next word (cmd = 1) answers with
// one span: row, clipped left/right columns, colour, a valid flag and a last
// flag; the split row of a two-half triangle comes out twice. Edges are 32-bit
// fixed point with FRAC_BITS fraction bits. Every division, on a magnitude of M =
// max(COORD_BITS + FRAC_BITS, 2*COORD_BITS + 2) bits, goes through the one shared
// divider at one quotient bit a cycle. A load divides the split column and then
// the two slopes; a flat half skips the split column and a rejected triangle skips
// every division. A next word is answered straight from the idle state, except that
// the word closing the first half is followed by a busy stretch while the second
// half's slopes are divided. The clip registers are taken on the cfg channel at any
// time (ready is held high) and read in the reject check, when a half is set up
// and when a span is clipped.
module triangle_span_rasterizer #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsr_pkg::CLIP_W-1:0]     cfg_data,
	// input words
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic signed [COORD_BITS-1:0]   vert_a_x,
	input  logic signed [COORD_BITS-1:0]   vert_a_y,
	input  logic signed [COORD_BITS-1:0]   vert_b_x,
	input  logic signed [COORD_BITS-1:0]   vert_b_y,
	input  logic signed [COORD_BITS-1:0]   vert_c_x,
	input  logic signed [COORD_BITS-1:0]   vert_c_y,
	input  logic [tsr_pkg::COLOR_W-1:0]    fill_color,
	// result words
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tsr_pkg::CLIP_W-1:0]     span_row,
	output logic [tsr_pkg::CLIP_W-1:0]     span_left,
	output logic [tsr_pkg::CLIP_W-1:0]     span_right,
	output logic [tsr_pkg::COLOR_W-1:0]    span_color,
	output logic                           span_valid,
	output logic                           last_span,
	output logic                           rejected
);
	import tsr_pkg::*;

	localparam int CW    = COORD_BITS;
	// row width: holds a coordinate and a clip value, signed
	localparam int RW    = ((CW > CLIP_W) ? CW : CLIP_W) + 1;
	localparam int MAG_W = ((CW + FRAC_BITS) > (2 * CW + 2)) ? (CW + FRAC_BITS) : (2 * CW + 2);
	localparam int NUM_W = MAG_W + 1;
	localparam int DEN_W = CW + 1;
	localparam int LW    = EDGE_W + 1 - FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_SORT, S_CHECK, S_NX_GO, S_NX_WAIT,
		S_DIVL_GO, S_DIVL_WAIT, S_DIVR_GO, S_DIVR_WAIT, S_ADVL, S_ADVR
	} state_t;

	state_t st_q;
	phase_t phase_q, next_phase_q;

	// clip registers
	logic [CLIP_W-1:0] cl_q, cr_q, ct_q, cb_q;

	// loaded and sorted vertices
	logic signed [CW-1:0] l_x1_q, l_y1_q, l_x2_q, l_y2_q, l_x3_q, l_y3_q;
	logic signed [CW-1:0] s_x1_q, s_y1_q, s_x2_q, s_y2_q, s_x3_q, s_y3_q;
	logic first_q, second_q, from_load_q;
	logic [COLOR_W-1:0] color_q;

	// second half, held across the first
	logic signed [CW-1:0] p_x2_q, p_y2_q, p_nx_q, p_x3_q, p_y3_q;

	// half setup
	logic signed [CW-1:0] hs_xs_q, hs_xe_q, hs_ys_q, hs_ye_q;
	logic signed [CW:0]   hs_dxl_q, hs_dxr_q;
	logic [CW-1:0]        hs_h_q;

	// edge walk
	logic [EDGE_W-1:0] edge_l_q, edge_r_q, slope_l_q, slope_r_q;
	logic signed [RW-1:0] cur_q, end_q;

	// result register
	logic               o_valid_q, o_span_q, o_last_q, o_rej_q;
	logic [CLIP_W-1:0]  o_row_q, o_left_q, o_right_q;
	logic [COLOR_W-1:0] o_color_q;

	// divider
	logic                   div_start, div_done;
	logic signed [NUM_W-1:0] div_num, div_quo;
	logic [DEN_W-1:0]       div_den;

	logic in_fire;
	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (st_q == S_IDLE) && (!o_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	logic signed [RW-1:0] e_cl, e_cr, e_ct, e_cb;
	assign e_cl = RW'(signed'({1'b0, cl_q}));
	assign e_cr = RW'(signed'({1'b0, cr_q}));
	assign e_ct = RW'(signed'({1'b0, ct_q}));
	assign e_cb = RW'(signed'({1'b0, cb_q}));

	function automatic logic rows_ok(input logic signed [RW-1:0] a, input logic signed [RW-1:0] b,
		input logic signed [RW-1:0] ct, input logic signed [RW-1:0] cb);
		logic signed [RW-1:0] lo, hi;
		lo = (a < ct) ? ct : a;
		hi = (b > cb) ? cb : b;
		return lo <= hi;
	endfunction

	// sort network over the loaded vertices (three compare-swaps)
	logic signed [CW-1:0] t_x1, t_y1, t_x2, t_y2, t_x3, t_y3, tmp;
	always_comb begin
		tmp = '0;
		t_x1 = l_x1_q; t_y1 = l_y1_q;
		t_x2 = l_x2_q; t_y2 = l_y2_q;
		t_x3 = l_x3_q; t_y3 = l_y3_q;
		if (t_y2 < t_y1) begin
			tmp = t_x1; t_x1 = t_x2; t_x2 = tmp;
			tmp = t_y1; t_y1 = t_y2; t_y2 = tmp;
		end
		if (t_y3 < t_y1) begin
			tmp = t_x1; t_x1 = t_x3; t_x3 = tmp;
			tmp = t_y1; t_y1 = t_y3; t_y3 = tmp;
		end
		if (t_y3 < t_y2) begin
			tmp = t_x2; t_x2 = t_x3; t_x3 = tmp;
			tmp = t_y2; t_y2 = t_y3; t_y3 = tmp;
		end
	end

	// trivial reject and row checks on sorted vertices
	logic signed [RW-1:0] e_x1, e_x2, e_x3, e_y1, e_y2, e_y3;
	logic degen, outside, re12, re23, re13;
	assign e_x1 = RW'(s_x1_q); assign e_x2 = RW'(s_x2_q); assign e_x3 = RW'(s_x3_q);
	assign e_y1 = RW'(s_y1_q); assign e_y2 = RW'(s_y2_q); assign e_y3 = RW'(s_y3_q);
	assign degen = (s_x1_q == s_x2_q && s_x2_q == s_x3_q) ||
		(s_y1_q == s_y2_q && s_y2_q == s_y3_q);
	assign outside = (e_y3 < e_ct) || (e_y1 > e_cb) ||
		(e_x1 < e_cl && e_x2 < e_cl && e_x3 < e_cl) ||
		(e_x1 > e_cr && e_x2 > e_cr && e_x3 > e_cr);
	assign re12 = rows_ok(e_y1, e_y2, e_ct, e_cb);
	assign re23 = rows_ok(e_y2, e_y3, e_ct, e_cb);
	assign re13 = rows_ok(e_y1, e_y3, e_ct, e_cb);

	// dropped triangle: degenerate, outside, or no drawable row in any half
	logic tri_drop, res_set;
	assign tri_drop = degen || outside ||
		(s_y1_q == s_y2_q && !re23) ||
		(s_y1_q != s_y2_q && s_y2_q == s_y3_q && !re13) ||
		(s_y1_q != s_y2_q && s_y2_q != s_y3_q && !re12 && !re23);
	// a result word is produced this cycle
	assign res_set = (in_fire && cmd != CMD_LOAD) ||
		(st_q == S_CHECK && tri_drop) ||
		(st_q == S_ADVR && from_load_q);

	// split column: x1 + (2*(y2-y1)*(x3-x1) + (y3-y1)) / (2*(y3-y1)), quotient truncated
	logic signed [CW:0]     nx_dy, nx_dx, nx_h;
	logic signed [2*CW+1:0] nx_prod;
	logic signed [CW-1:0]   nx;
	assign nx_dy   = (CW+1)'(s_y2_q) - (CW+1)'(s_y1_q);
	assign nx_dx   = (CW+1)'(s_x3_q) - (CW+1)'(s_x1_q);
	assign nx_h    = (CW+1)'(s_y3_q) - (CW+1)'(s_y1_q);
	assign nx_prod = nx_dy * nx_dx;
	assign nx      = CW'(NUM_W'(s_x1_q) + div_quo);

	// half setup source: A apex or first top vertex, B/C the others
	logic signed [CW-1:0] hp_a, hp_b, hp_c, hp_yt, hp_yb, hp_lo, hp_hi;
	logic signed [CW-1:0] hp_xs, hp_xe;
	logic signed [CW:0]   hp_dxl, hp_dxr, hp_h;
	logic                 hp_top;
	always_comb begin
		case (st_q)
			S_CHECK: begin
				hp_a = s_x1_q; hp_b = s_x2_q; hp_c = s_x3_q;
				hp_yt = s_y1_q; hp_yb = s_y3_q; hp_top = (s_y1_q == s_y2_q);
			end
			S_NX_WAIT: begin
				if (first_q) begin
					hp_a = s_x1_q; hp_b = nx; hp_c = s_x2_q;
					hp_yt = s_y1_q; hp_yb = s_y2_q; hp_top = 1'b0;
				end else begin
					hp_a = s_x2_q; hp_b = nx; hp_c = s_x3_q;
					hp_yt = s_y2_q; hp_yb = s_y3_q; hp_top = 1'b1;
				end
			end
			default: begin
				hp_a = p_x2_q; hp_b = p_nx_q; hp_c = p_x3_q;
				hp_yt = p_y2_q; hp_yb = p_y3_q; hp_top = 1'b1;
			end
		endcase
		if (hp_top) begin
			hp_lo = (hp_b < hp_a) ? hp_b : hp_a;
			hp_hi = (hp_b < hp_a) ? hp_a : hp_b;
			hp_xs = hp_lo;
			hp_xe = hp_hi;
			hp_dxl = (CW+1)'(hp_c) - (CW+1)'(hp_lo);
			hp_dxr = (CW+1)'(hp_c) - (CW+1)'(hp_hi);
		end else begin
			hp_lo = (hp_c < hp_b) ? hp_c : hp_b;
			hp_hi = (hp_c < hp_b) ? hp_b : hp_c;
			hp_xs = hp_a;
			hp_xe = hp_a;
			hp_dxl = (CW+1)'(hp_lo) - (CW+1)'(hp_a);
			hp_dxr = (CW+1)'(hp_hi) - (CW+1)'(hp_a);
		end
		hp_h = (CW+1)'(hp_yb) - (CW+1)'(hp_yt);
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (st_q)
			S_NX_GO: begin
				div_start = 1'b1;
				div_num   = (NUM_W'(nx_prod) <<< 1) + NUM_W'(nx_h);
				div_den   = DEN_W'(nx_h) << 1;
			end
			S_DIVL_GO: begin
				div_start = 1'b1;
				div_num   = NUM_W'(hs_dxl_q) <<< FRAC_BITS;
				div_den   = DEN_W'(hs_h_q);
			end
			S_DIVR_GO: begin
				div_start = 1'b1;
				div_num   = NUM_W'(hs_dxr_q) <<< FRAC_BITS;
				div_den   = DEN_W'(hs_h_q);
			end
			default: ;
		endcase
	end

	tsr_div #(.MAG_W(MAG_W), .DEN_W(DEN_W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// advance a half that starts above clip_top: edge += slope * rows skipped
	logic [RW-1:0]     adv_k;
	logic [EDGE_W-1:0] adv_slope, adv_prod, xs_fx, xe_fx;
	logic signed [RW-1:0] e_ys, e_ye, row_lo, row_hi;
	assign e_ys      = RW'(hs_ys_q);
	assign e_ye      = RW'(hs_ye_q);
	assign adv_k     = (e_ys < e_ct) ? RW'(e_ct - e_ys) : '0;
	assign adv_slope = (st_q == S_ADVL) ? slope_l_q : slope_r_q;
	assign adv_prod  = EDGE_W'(adv_slope * EDGE_W'(adv_k));
	assign xs_fx     = EDGE_W'(hs_xs_q) << FRAC_BITS;
	assign xe_fx     = EDGE_W'(hs_xe_q) << FRAC_BITS;
	assign row_lo    = (e_ys < e_ct) ? e_ct : e_ys;
	assign row_hi    = (e_ye > e_cb) ? e_cb : e_ye;

	// span columns: floor(edge + 0.5), then clip
	localparam logic signed [EDGE_W:0] HALF = (EDGE_W+1)'(1) <<< (FRAC_BITS - 1);
	logic signed [EDGE_W:0] lsum, rsum;
	logic signed [LW-1:0]   sp_l, sp_r, lc_l, lc_r, w_cl, w_cr;
	logic                   sp_ok;
	assign lsum = (EDGE_W+1)'(signed'(edge_l_q)) + HALF;
	assign rsum = (EDGE_W+1)'(signed'(edge_r_q)) + HALF;
	assign sp_l = LW'(lsum >>> FRAC_BITS);
	assign sp_r = LW'(rsum >>> FRAC_BITS);
	assign w_cl = LW'(signed'({1'b0, cl_q}));
	assign w_cr = LW'(signed'({1'b0, cr_q}));
	always_comb begin
		sp_ok = 1'b1;
		lc_l  = sp_l;
		lc_r  = sp_r;
		if (lc_l < w_cl) begin
			lc_l = w_cl;
			if (lc_r < w_cl) sp_ok = 1'b0;
		end
		if (sp_ok && lc_r > w_cr) begin
			lc_r = w_cr;
			if (lc_l > w_cr) sp_ok = 1'b0;
		end
		if (sp_ok && lc_l > lc_r) sp_ok = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			phase_q <= PH_IDLE;
			next_phase_q <= PH_IDLE;
			cl_q <= CLIP_LEFT_RST;
			cr_q <= CLIP_RIGHT_RST;
			ct_q <= CLIP_TOP_RST;
			cb_q <= CLIP_BOTTOM_RST;
			first_q <= 1'b0;
			second_q <= 1'b0;
			from_load_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_CLIP_LEFT:   cl_q <= cfg_data;
					REG_CLIP_RIGHT:  cr_q <= cfg_data;
					REG_CLIP_TOP:    ct_q <= cfg_data;
					REG_CLIP_BOTTOM: cb_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_set) o_valid_q <= 1'b1;
			else if (out_ready) o_valid_q <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (in_fire) begin
						if (cmd == CMD_LOAD) begin
							l_x1_q <= vert_a_x; l_y1_q <= vert_a_y;
							l_x2_q <= vert_b_x; l_y2_q <= vert_b_y;
							l_x3_q <= vert_c_x; l_y3_q <= vert_c_y;
							color_q <= fill_color;
							phase_q <= PH_IDLE;
							from_load_q <= 1'b1;
							st_q <= S_SORT;
						end else if (phase_q == PH_IDLE) begin
							o_row_q <= '0; o_left_q <= '0; o_right_q <= '0;
							o_color_q <= '0; o_span_q <= 1'b0;
							o_last_q <= 1'b1; o_rej_q <= 1'b0;
						end else begin
							o_row_q   <= cur_q[CLIP_W-1:0];
							o_color_q <= color_q;
							o_left_q  <= sp_ok ? lc_l[CLIP_W-1:0] : '0;
							o_right_q <= sp_ok ? lc_r[CLIP_W-1:0] : '0;
							o_span_q  <= sp_ok;
							o_rej_q   <= 1'b0;
							// final row of the final half closes the triangle
							o_last_q  <= (cur_q >= end_q) && (phase_q != PH_MORE);
							edge_l_q <= edge_l_q + slope_l_q;
							edge_r_q <= edge_r_q + slope_r_q;
							if (cur_q >= end_q) begin
								if (phase_q == PH_MORE) begin
									// split row reached: set up the flat-top half
									hs_xs_q <= hp_xs; hs_xe_q <= hp_xe;
									hs_dxl_q <= hp_dxl; hs_dxr_q <= hp_dxr;
									hs_h_q <= (hp_h <= 0) ? CW'(1) : hp_h[CW-1:0];
									hs_ys_q <= hp_yt; hs_ye_q <= hp_yb;
									phase_q <= PH_FINAL;
									from_load_q <= 1'b0;
									st_q <= S_DIVL_GO;
								end else begin
									phase_q <= PH_IDLE;
								end
							end else begin
								cur_q <= cur_q + 1'b1;
							end
						end
					end
				end
				S_SORT: begin
					s_x1_q <= t_x1; s_y1_q <= t_y1;
					s_x2_q <= t_x2; s_y2_q <= t_y2;
					s_x3_q <= t_x3; s_y3_q <= t_y3;
					st_q <= S_CHECK;
				end
				S_CHECK: begin
					if (tri_drop) begin
						o_row_q <= '0; o_left_q <= '0; o_right_q <= '0;
						o_color_q <= '0; o_span_q <= 1'b0;
						o_last_q <= 1'b0; o_rej_q <= 1'b1;
						st_q <= S_IDLE;
					end else if (s_y1_q == s_y2_q || s_y2_q == s_y3_q) begin
						hs_xs_q <= hp_xs; hs_xe_q <= hp_xe;
						hs_dxl_q <= hp_dxl; hs_dxr_q <= hp_dxr;
						hs_h_q <= (hp_h <= 0) ? CW'(1) : hp_h[CW-1:0];
						hs_ys_q <= hp_yt; hs_ye_q <= hp_yb;
						next_phase_q <= PH_FINAL;
						st_q <= S_DIVL_GO;
					end else begin
						first_q <= re12;
						second_q <= re23;
						st_q <= S_NX_GO;
					end
				end
				S_NX_GO: st_q <= S_NX_WAIT;
				S_NX_WAIT: begin
					if (div_done) begin
						p_x2_q <= s_x2_q; p_y2_q <= s_y2_q; p_nx_q <= nx;
						p_x3_q <= s_x3_q; p_y3_q <= s_y3_q;
						hs_xs_q <= hp_xs; hs_xe_q <= hp_xe;
						hs_dxl_q <= hp_dxl; hs_dxr_q <= hp_dxr;
						hs_h_q <= (hp_h <= 0) ? CW'(1) : hp_h[CW-1:0];
						hs_ys_q <= hp_yt; hs_ye_q <= hp_yb;
						next_phase_q <= (first_q && second_q) ? PH_MORE : PH_FINAL;
						st_q <= S_DIVL_GO;
					end
				end
				S_DIVL_GO: st_q <= S_DIVL_WAIT;
				S_DIVL_WAIT: begin
					if (div_done) begin
						slope_l_q <= EDGE_W'(div_quo);
						st_q <= S_DIVR_GO;
					end
				end
				S_DIVR_GO: st_q <= S_DIVR_WAIT;
				S_DIVR_WAIT: begin
					if (div_done) begin
						slope_r_q <= EDGE_W'(div_quo);
						st_q <= S_ADVL;
					end
				end
				S_ADVL: begin
					edge_l_q <= xs_fx + adv_prod;
					st_q <= S_ADVR;
				end
				S_ADVR: begin
					edge_r_q <= xe_fx + adv_prod;
					cur_q <= row_lo;
					end_q <= row_hi;
					if (from_load_q) begin
						// load reply: accepted triangle
						phase_q <= next_phase_q;
						o_row_q <= '0; o_left_q <= '0; o_right_q <= '0;
						o_color_q <= '0; o_span_q <= 1'b0;
						o_last_q <= 1'b0; o_rej_q <= 1'b0;
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = o_valid_q;
	assign span_row   = o_row_q;
	assign span_left  = o_left_q;
	assign span_right = o_right_q;
	assign span_color = o_color_q;
	assign span_valid = o_span_q;
	assign last_span  = o_last_q;
	assign rejected   = o_rej_q;

endmodule

// ----- sv/tsr_checker.sv -----
// tsr_checker: port-level checks for triangle_span_rasterizer, bound below.
// Depends on tsr_pkg for field widths.
module tsr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [tsr_pkg::CLIP_W-1:0] span_row,
	input logic [tsr_pkg::CLIP_W-1:0] span_left,
	input logic [tsr_pkg::CLIP_W-1:0] span_right,
	input logic span_valid,
	input logic last_span,
	input logic rejected
);
	import tsr_pkg::*;

	// a waiting word blocks new input
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result word stalled");

	// rejected load reply carries no row and no span flags
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> !span_valid && !last_span && span_row == '0)
		else $error("rejected reply carries span data");

	// invalid span has zero columns
	a_invalid_cols: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !span_valid |-> span_left == '0 && span_right == '0)
		else $error("invalid span with nonzero columns");

	// drawn span is ordered and not flagged rejected
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_valid |-> span_left <= span_right && !rejected)
		else $error("span left beyond right");

	// stalled result word holds its row and left column
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(span_row) && $stable(span_left))
		else $error("result word changed while stalled");

endmodule

bind triangle_span_rasterizer tsr_checker u_tsr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.span_row(span_row),
	.span_left(span_left),
	.span_right(span_right),
	.span_valid(span_valid),
	.last_span(last_span),
	.rejected(rejected)
);

// ----- tb/tb_triangle_span_rasterizer.sv -----
`timescale 1ns / 1ps
// tb_triangle_span_rasterizer: self-checking bench for the span rasterizer.
// Depends on tsr_pkg and the triangle_span_rasterizer top level.
// Directed table first, then random triangles checked by a span predictor.
module tb_triangle_span_rasterizer;
	import tsr_pkg::*;

	localparam int  FRAC = 16;
	localparam longint HALF = longint'(1) << (FRAC - 1);
	localparam longint ONE  = longint'(1) << FRAC;

	typedef struct {
		logic                cmd;
		logic signed [11:0]  ax, ay, bx, by, cx, cy;
		logic [15:0]         color;
	} word_t;

	typedef struct {
		logic [10:0] row, left, right;
		logic [15:0] color;
		logic        valid, last, rej;
	} span_t;

	// directed row: stimulus word plus an optional typed-in answer
	typedef struct {
		word_t w;
		bit    typed;
		span_t ans;
	} row_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CLIP_W-1:0] cfg_data;
	logic in_valid, in_ready, cmd;
	logic signed [11:0] vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y;
	logic [15:0] fill_color;
	logic out_valid, out_ready;
	logic [10:0] span_row, span_left, span_right;
	logic [15:0] span_color;
	logic span_valid, last_span, rejected;

	triangle_span_rasterizer dut (.*);

	// predictor state
	longint clip_l, clip_r, clip_t, clip_b;
	bit [31:0] lx, rx, lslope, rslope;
	longint cur_row, end_row;
	longint pend[5];
	phase_t phase;
	logic [15:0] held_col;

	span_t spans_due[$];
	row_t  dir_rows[$];
	int    errors, words_sent, spans_seen, loads_sent;
	bit    calm, long_hold;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// generous fixed time limit; reaching it fails the run
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint row_lo(longint y);
		return (y < clip_t) ? clip_t : y;
	endfunction

	function automatic longint row_hi(longint y);
		return (y > clip_b) ? clip_b : y;
	endfunction

	// edges start at xs/xe on row ys; a start above clip_top is stepped down to it
	function automatic void edge_setup(longint xs, longint xe, longint dl, longint dr,
					   longint ys, longint ye);
		bit [31:0] k;
		lx = xs[31:0];
		rx = xe[31:0];
		if (ys < clip_t) begin
			k = 32'(clip_t - ys);
			lx = lx + dl[31:0] * k;
			rx = rx + dr[31:0] * k;
		end
		lslope = dl[31:0];
		rslope = dr[31:0];
		cur_row = row_lo(ys);
		end_row = row_hi(ye);
	endfunction

	function automatic void flat_top(longint xa, longint xb, longint yab, longint xc,
					 longint yc);
		longint t, h;
		h = yc - yab;
		if (xb < xa) begin t = xa; xa = xb; xb = t; end
		if (h <= 0) h = 1;
		edge_setup(xa * ONE, xb * ONE, ((xc - xa) * ONE) / h, ((xc - xb) * ONE) / h,
			   yab, yc);
	endfunction

	function automatic void flat_bottom(longint xa, longint ya, longint xb, longint xc,
					    longint ybc);
		longint t, h;
		h = ybc - ya;
		if (xc < xb) begin t = xb; xb = xc; xc = t; end
		if (h <= 0) h = 1;
		edge_setup(xa * ONE, xa * ONE, ((xb - xa) * ONE) / h, ((xc - xa) * ONE) / h,
			   ya, ybc);
	endfunction

	// returns 1 when the triangle is dropped
	function automatic bit tri_setup(word_t w);
		longint x1, y1, x2, y2, x3, y3, t, nx;
		bit first, second;
		x1 = w.ax; y1 = w.ay; x2 = w.bx; y2 = w.by; x3 = w.cx; y3 = w.cy;
		phase = PH_IDLE;
		held_col = w.color;
		if ((x1 == x2 && x2 == x3) || (y1 == y2 && y2 == y3)) return 1;
		if (y2 < y1) begin t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t; end
		if (y3 < y1) begin t = x1; x1 = x3; x3 = t; t = y1; y1 = y3; y3 = t; end
		if (y3 < y2) begin t = x2; x2 = x3; x3 = t; t = y2; y2 = y3; y3 = t; end
		if (y3 < clip_t || y1 > clip_b || (x1 < clip_l && x2 < clip_l && x3 < clip_l) ||
		    (x1 > clip_r && x2 > clip_r && x3 > clip_r))
			return 1;
		if (y1 == y2) begin
			if (row_lo(y2) > row_hi(y3)) return 1;
			flat_top(x1, x2, y1, x3, y3);
			phase = PH_FINAL;
		end else if (y2 == y3) begin
			if (row_lo(y1) > row_hi(y3)) return 1;
			flat_bottom(x1, y1, x2, x3, y3);
			phase = PH_FINAL;
		end else begin
			// split column, (2*dy*dx + h) / (2*h) truncated toward zero, exact
			nx = x1 + (2 * (y2 - y1) * (x3 - x1) + (y3 - y1)) / (2 * (y3 - y1));
			pend[0] = x2; pend[1] = y2; pend[2] = nx; pend[3] = x3; pend[4] = y3;
			first = row_lo(y1) <= row_hi(y2);
			second = row_lo(y2) <= row_hi(y3);
			if (first) begin
				flat_bottom(x1, y1, nx, x2, y2);
				phase = second ? PH_MORE : PH_FINAL;
			end else if (second) begin
				flat_top(x2, nx, y2, x3, y3);
				phase = PH_FINAL;
			end else
				return 1;
		end
		return 0;
	endfunction

	function automatic span_t next_span(word_t w);
		span_t r;
		longint lft, rgt;
		bit ok;
		r = '{default: '0};
		ok = 1;
		if (w.cmd == CMD_LOAD) begin
			r.rej = tri_setup(w);
			return r;
		end
		if (phase == PH_IDLE) begin
			r.last = 1;
			return r;
		end
		lft = (longint'($signed(lx)) + HALF) >>> FRAC;
		rgt = (longint'($signed(rx)) + HALF) >>> FRAC;
		lx = lx + lslope;
		rx = rx + rslope;
		if (lft < clip_l) begin
			lft = clip_l;
			if (rgt < clip_l) ok = 0;
		end
		if (ok && rgt > clip_r) begin
			rgt = clip_r;
			if (lft > clip_r) ok = 0;
		end
		if (ok && lft > rgt) ok = 0;
		r.row = cur_row[10:0];
		r.color = held_col;
		if (ok) begin
			r.left = lft[10:0];
			r.right = rgt[10:0];
			r.valid = 1;
		end
		if (cur_row >= end_row) begin
			if (phase == PH_MORE) begin
				flat_top(pend[0], pend[2], pend[1], pend[3], pend[4]);
				phase = PH_FINAL;
			end else begin
				phase = PH_IDLE;
				r.last = 1;
			end
		end else
			cur_row++;
		return r;
	endfunction

	// one input word; entered right after a falling edge, leaves after one
	task automatic send_word(word_t w, bit typed, span_t ans);
		span_t p;
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		cmd <= w.cmd;
		vert_a_x <= w.ax; vert_a_y <= w.ay;
		vert_b_x <= w.bx; vert_b_y <= w.by;
		vert_c_x <= w.cx; vert_c_y <= w.cy;
		fill_color <= w.color;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = next_span(w);
		spans_due.push_back(typed ? ans : p);
		words_sent++;
		if (w.cmd == CMD_LOAD) loads_sent++;
		@(negedge clk);
	endtask

	// wait out all answers plus the block's longest busy tail, then write the clips
	task automatic set_clips(int l, int r, int t, int b);
		int vals[4];
		in_valid <= 0;
		wait (spans_due.size() == 0);
		repeat (150) @(negedge clk);
		vals = '{l, r, t, b};
		for (int i = 0; i < 4; i++) begin
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= CLIP_W'(vals[i]);
			cfg_valid <= 1;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (CFG_IDX_W'(i))
				REG_CLIP_LEFT:   clip_l = vals[i];
				REG_CLIP_RIGHT:  clip_r = vals[i];
				REG_CLIP_TOP:    clip_t = vals[i];
				REG_CLIP_BOTTOM: clip_b = vals[i];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic word_t mk(logic c, int ax, int ay, int bx, int by, int cx, int cy,
				     int col);
		word_t w;
		w.cmd = c;
		w.ax = 12'(ax); w.ay = 12'(ay); w.bx = 12'(bx);
		w.by = 12'(by); w.cx = 12'(cx); w.cy = 12'(cy);
		w.color = 16'(col);
		return w;
	endfunction

	function automatic void add_row(word_t w, bit typed, bit rej, bit last);
		row_t r;
		r.w = w;
		r.typed = typed;
		r.ans = '{default: '0};
		r.ans.rej = rej;
		r.ans.last = last;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_next(int n);
		for (int i = 0; i < n; i++) add_row(mk(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
	endfunction

	// random triangle near the top-left corner of the clip window, or anywhere when wide
	function automatic word_t rand_tri(bit wide);
		word_t w;
		int bx, by;
		w.cmd = CMD_LOAD;
		w.color = 16'($urandom);
		if (wide) begin
			{w.ax, w.ay, w.bx, w.by} = 48'({$urandom, $urandom});
			{w.cx, w.cy} = 24'($urandom);
		end else begin
			bx = int'(clip_l) + $urandom_range(0, 80) - 40;
			by = int'(clip_t) + $urandom_range(0, 60) - 20;
			w.ax = 12'(bx + $urandom_range(0, 50)); w.ay = 12'(by + $urandom_range(0, 30));
			w.bx = 12'(bx + $urandom_range(0, 50)); w.by = 12'(by + $urandom_range(0, 30));
			w.cx = 12'(bx + $urandom_range(0, 50)); w.cy = 12'(by + $urandom_range(0, 30));
		end
		return w;
	endfunction

	// a noise word, or a load and span requests until the triangle runs out
	task automatic draw_one();
		span_t none;
		word_t w, nw;
		int extra, cut;
		none = '{default: '0};
		nw = mk(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0);
		if ($urandom_range(0, 19) == 0) begin
			// noise word with random command and fields
			w = rand_tri(1);
			w.cmd = 1'($urandom_range(0, 1));
			send_word(w, 0, none);
			return;
		end
		send_word(rand_tri($urandom_range(0, 9) == 0), 0, none);
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 1 << 30;
		while (phase != PH_IDLE && cut > 0) begin
			send_word(nw, 0, none);
			cut--;
		end
		extra = ($urandom_range(0, 3) == 0) ? 1 : 0;
		repeat (extra) send_word(nw, 0, none);
	endtask

	// receiver: random stall bursts, one long hold on request
	initial begin
		int stall;
		out_ready = 0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				long_hold = 0;
				out_ready <= 1;
			end else if (calm) begin
				out_ready <= 1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall = $urandom_range(0, 9);
				out_ready <= 0;
			end else
				out_ready <= 1;
		end
	end

	// result checker against the oldest expected word
	always @(posedge clk) begin
		span_t e;
		if (arst_n && out_valid && out_ready) begin
			spans_seen++;
			if (spans_due.size() == 0) begin
				$display("%0t unexpected word row=%0d", $time, span_row);
				errors++;
			end else begin
				e = spans_due.pop_front();
				if ({span_row, span_left, span_right, span_color, span_valid, last_span,
				     rejected} !== {e.row, e.left, e.right, e.color, e.valid, e.last,
				     e.rej}) begin
					$display("%0t mismatch exp row=%0d l=%0d r=%0d col=%h v=%b last=%b rej=%b",
						 $time, e.row, e.left, e.right, e.color, e.valid, e.last, e.rej);
					$display("%0t          got row=%0d l=%0d r=%0d col=%h v=%b last=%b rej=%b",
						 $time, span_row, span_left, span_right, span_color, span_valid,
						 last_span, rejected);
					errors++;
				end
			end
		end
	end

	initial begin
		int per_phase;
		errors = 0; words_sent = 0; spans_seen = 0; loads_sent = 0;
		calm = 0; long_hold = 0;
		arst_n = 0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; cmd = CMD_NEXT;
		vert_a_x = 0; vert_a_y = 0; vert_b_x = 0; vert_b_y = 0; vert_c_x = 0; vert_c_y = 0;
		fill_color = 0;
		clip_l = CLIP_LEFT_RST; clip_r = CLIP_RIGHT_RST;
		clip_t = CLIP_TOP_RST; clip_b = CLIP_BOTTOM_RST;
		lx = 0; rx = 0; lslope = 0; rslope = 0; cur_row = 0; end_row = 0;
		pend = '{0, 0, 0, 0, 0};
		phase = PH_IDLE; held_col = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed table at the reset clip window
		add_row(mk(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1);           // idle request
		add_row(mk(CMD_LOAD, 5, 1, 5, 9, 5, 20, 16'h1234), 1, 1, 0);    // one column
		add_row(mk(CMD_LOAD, 1, 7, 30, 7, 9, 7, 16'h1234), 1, 1, 0);    // one row
		add_row(mk(CMD_LOAD, 3, -2048, 9, -10, 40, -5, 0), 1, 1, 0);    // above top
		add_row(mk(CMD_LOAD, 2047, 5, 1000, 9, 700, 30, 0), 1, 1, 0);   // right of clip
		add_row(mk(CMD_LOAD, -2048, 5, -1, 9, -7, 30, 0), 1, 1, 0);     // left of clip
		add_row(mk(CMD_LOAD, -2048, -2048, 2047, 0, 0, 2047, 16'hFFFF), 1, 0, 0);
		add_next(2);
		add_row(mk(CMD_LOAD, 10, 10, 20, 10, 15, 14, 16'hA5A5), 1, 0, 0); // flat top
		add_next(6);                                                   // runs past end
		add_row(mk(CMD_LOAD, 15, 20, 10, 24, 20, 24, 16'h5A5A), 1, 0, 0); // flat bottom
		add_next(2);
		add_row(mk(CMD_LOAD, 5, 30, 40, 35, 0, 40, 16'h0F0F), 0, 0, 0);   // abandons
		add_next(8);                                                   // split row
		add_row(mk(CMD_LOAD, -20, 50, 700, 50, 300, 53, 16'h00FF), 0, 0, 0); // wide
		add_next(2);
		foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].ans);

		// random phases over several clip windows, extremes among them
		per_phase = 900 / 7;
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: ;
				1: set_clips(0, 2047, 0, 2047);
				2: set_clips(0, 0, 0, 0);
				3: set_clips(2047, 2047, 2047, 2047);
				4: set_clips(300, 200, 300, 200);
				5: set_clips($urandom_range(0, 2047), $urandom_range(0, 2047),
					     $urandom_range(0, 2047), $urandom_range(0, 2047));
				6: begin
					set_clips($urandom_range(0, 100), $urandom_range(100, 700),
						  $urandom_range(0, 100), $urandom_range(100, 500));
					calm = 1;
				end
				default: ;
			endcase
			begin
				int start;
				start = words_sent;
				while (words_sent - start < per_phase) begin
					draw_one();
					if (ph == 1 && words_sent - start > 40 && words_sent - start < 45)
						long_hold = 1;
					if (ph == 5 && words_sent - start > 50 && words_sent - start < 53) begin
						// sender pause until the pipe is empty
						in_valid <= 0;
						wait (spans_due.size() == 0);
						@(negedge clk);
					end
				end
			end
		end

		in_valid <= 0;
		wait (spans_due.size() == 0);
		repeat (200) @(posedge clk);
		$display("covered %0d words (%0d loads), %0d results checked over 7 clip windows",
			 words_sent, loads_sent, spans_seen);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- triangle_span_rasterizer.f -----
sv/tsr_pkg.sv
sv/tsr_div.sv
sv/triangle_span_rasterizer.sv
sv/tsr_checker.sv
tb/tb_triangle_span_rasterizer.sv
